// File: hdl/ustv_pkg.sv
// Shared types, constants and helpers for the UTF-8 string table validator.
package ustv_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int MAX_BITS    = 16;
    localparam int CMP_BITS    = ((LENGTH_BITS > MAX_BITS) ? LENGTH_BITS : MAX_BITS) + 1;
    localparam int CP_BITS     = 21;

    localparam logic [CP_BITS-1:0]  CP_LIMIT       = 21'h10ffff;
    localparam logic [CP_BITS-1:0]  SURROGATE_LO   = 21'h00d800;
    localparam logic [CP_BITS-1:0]  SURROGATE_HI   = 21'h00dfff;
    localparam logic [MAX_BITS-1:0] MAX_LEN_RESET  = 16'd255;

    localparam logic [1:0] CLASS_NONE  = 2'd0;
    localparam logic [1:0] CLASS_TWO   = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR  = 2'd3;

    typedef struct packed {
        logic                   at_table_start;
        logic [LENGTH_BITS-1:0] string_length;
        logic [1:0]             bytes_pending;
        logic [CP_BITS-1:0]     code_point;
        logic [1:0]             minimum_class;
        logic                   error_seen;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        at_table_start: 1'b1,
        string_length:  '0,
        bytes_pending:  2'd0,
        code_point:     '0,
        minimum_class:  CLASS_NONE,
        error_seen:     1'b0
    };

    function automatic logic [CP_BITS-1:0] class_minimum(input logic [1:0] cls);
        logic [CP_BITS-1:0] m;
        unique case (cls)
            CLASS_TWO:   m = 21'h000080;
            CLASS_THREE: m = 21'h000800;
            CLASS_FOUR:  m = 21'h010000;
            default:     m = '0;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/ustv_step.sv
// Per-byte decode: next scan state and verdict for one table byte.
module ustv_step
    import ustv_pkg::*;
(
    input  scan_state_t          cur,
    input  logic [MAX_BITS-1:0]  max_string_bytes,
    input  logic [7:0]           byte_value,
    input  logic                 last_byte,
    output scan_state_t          nxt,
    output logic                 failed
);

    logic [CMP_BITS-1:0] len_ext;
    logic [CMP_BITS-1:0] len_inc;
    logic [CMP_BITS-1:0] max_ext;
    logic [CMP_BITS-1:0] len_ones;
    logic [CP_BITS-1:0]  cp_shift;
    logic                err;
    scan_state_t         work;

    assign len_ext  = CMP_BITS'(cur.string_length);
    assign len_inc  = len_ext + CMP_BITS'(1);
    assign max_ext  = CMP_BITS'(max_string_bytes);
    assign len_ones = CMP_BITS'({LENGTH_BITS{1'b1}});
    assign cp_shift = {cur.code_point[CP_BITS-7:0], byte_value[5:0]};

    always_comb
    begin
        work = cur;
        err  = cur.error_seen;
        if (cur.at_table_start && byte_value != 8'd0)
        begin
            err = 1'b1;
        end
        work.at_table_start = 1'b0;

        if (byte_value == 8'd0)
        begin
            if (cur.bytes_pending != 2'd0 || len_ext > max_ext)
            begin
                err = 1'b1;
            end
            work.string_length = '0;
            work.bytes_pending = 2'd0;
        end
        else
        begin
            if (len_inc > max_ext || len_inc > len_ones)
            begin
                err = 1'b1;
            end
            work.string_length = (len_inc > len_ones) ? cur.string_length
                                                      : len_inc[LENGTH_BITS-1:0];

            if (cur.bytes_pending != 2'd0)
            begin
                if (byte_value[7:6] != 2'b10)
                begin
                    err = 1'b1;
                    work.bytes_pending = 2'd0;
                end
                else
                begin
                    work.code_point    = cp_shift;
                    work.bytes_pending = cur.bytes_pending - 2'd1;
                    if (cur.bytes_pending == 2'd1 &&
                        (cp_shift < class_minimum(cur.minimum_class) ||
                         cp_shift > CP_LIMIT ||
                         (cp_shift >= SURROGATE_LO && cp_shift <= SURROGATE_HI)))
                    begin
                        err = 1'b1;
                    end
                end
            end
            else
            begin
                priority if (byte_value[7] == 1'b0)
                begin
                    // plain ASCII
                end
                else if (byte_value[7:5] == 3'b110)
                begin
                    work.bytes_pending = 2'd1;
                    work.code_point    = CP_BITS'(byte_value[4:0]);
                    work.minimum_class = CLASS_TWO;
                end
                else if (byte_value[7:4] == 4'b1110)
                begin
                    work.bytes_pending = 2'd2;
                    work.code_point    = CP_BITS'(byte_value[3:0]);
                    work.minimum_class = CLASS_THREE;
                end
                else if (byte_value[7:3] == 5'b11110)
                begin
                    work.bytes_pending = 2'd3;
                    work.code_point    = CP_BITS'(byte_value[2:0]);
                    work.minimum_class = CLASS_FOUR;
                end
                else
                begin
                    err = 1'b1;
                end
            end
        end
        work.error_seen = err;

        failed = err;
        if (last_byte && (work.bytes_pending != 2'd0 || byte_value != 8'd0))
        begin
            failed = 1'b1;
        end
        nxt = last_byte ? SCAN_RESET : work;
    end

endmodule

// File: hdl/utf8_string_table_validator.sv
// Top level of the UTF-8 string table validator: word registers, scan state, config.
//
// Takes one table byte per word and returns one result word per byte, sustaining one
// word per clock. A byte is decoded against the scan state while it sits in the input
// register, and its result is loaded into the output register once that register is
// empty or being taken. Input stalls only while a result waits in the output register
// and is not taken. The error flag is sticky within a table. The word marked last
// carries the final verdict in failed, with finished high, and the scan state then
// returns to its reset values. max_string_bytes (reset 255) is written through
// cfg_write/cfg_data; the user must write it only while idle, which the block does
// not enforce.
module utf8_string_table_validator
    import ustv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [MAX_BITS-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_value,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                failed,
    output logic                finished
);

    logic [MAX_BITS-1:0] max_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    logic                out_failed_reg;
    logic                out_finished_reg;
    scan_state_t         state_reg;
    scan_state_t         state_next;
    logic                failed_next;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    ustv_step u_step (
        .cur              (state_reg),
        .max_string_bytes (max_reg),
        .byte_value       (in_byte_reg),
        .last_byte        (in_last_reg),
        .nxt              (state_next),
        .failed           (failed_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_LEN_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                max_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= byte_value;
            in_last_reg <= last_byte;
        end
        if (advance)
        begin
            out_failed_reg   <= failed_next;
            out_finished_reg <= in_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign failed    = out_failed_reg;
    assign finished  = out_finished_reg;

endmodule
